/* sv/owt_pkg.sv */
// ----------------------------------------------------------------------------
// owt_pkg - shared types and constants for the one-wire temperature reader
// Field widths, configuration and result bundles used across the block.
// ----------------------------------------------------------------------------
package owt_pkg;

	localparam int COUNT_W    = 20;
	localparam int TEMP_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;
	localparam int S_TDATA_W  = 8;
	localparam int M_TDATA_W  = 24;

	typedef struct packed {
		logic [9:0]         reset_pulse_ticks;
		logic [7:0]         presence_delay_ticks;
		logic [9:0]         presence_hold_ticks;
		logic [3:0]         low_pulse_ticks;
		logic [7:0]         slot_ticks;
		logic [5:0]         sample_ticks;
		logic [7:0]         read_tail_ticks;
		logic [COUNT_W-1:0] conversion_ticks;
	} cfg_t;

	typedef struct packed {
		logic start_req;
		logic line_level;
	} tick_t;

	typedef struct packed {
		logic                     drive_low;
		logic                     busy_res;
		logic                     done_res;
		logic signed [TEMP_W-1:0] temperature;
	} res_t;

endpackage

/* sv/onewire_temperature_reader.sv */
// ----------------------------------------------------------------------------
// onewire_temperature_reader - one-wire skip-ROM temperature reader
// Tick-driven one-wire master that runs a convert and scratchpad read.
// ----------------------------------------------------------------------------
// Every request on the input stream is one microsecond tick carrying a start
// flag and the sampled bus level; every tick yields exactly one response with
// the line drive for that tick, busy, a done pulse and the last temperature
// (signed, 1/16 degC). A start in idle begins the sequence on the same tick:
// reset pulse, presence wait (no timeout), hold, skip-ROM + convert, the
// conversion wait, a second reset and presence, skip-ROM + read scratchpad,
// then two read bytes, low byte first. Writing a one only releases the line.
// Throughput is one tick per clock cycle while responses are not stalled;
// a tick passes the input register, then the response register, with the
// sequencer's single next-state pass between them. The input register also
// acts as a skid stage, so a request is still taken while a response waits.
// Timing registers are written through cfg_we/cfg_index/cfg_wdata; the user
// must write them only while the block is idle, which the block does not enforce.
// The sequence state only advances when a tick moves into the response register.
// ----------------------------------------------------------------------------
module onewire_temperature_reader (
	input  logic                           clk,
	input  logic                           arst_n,
	// slave side: [0] start_req, [1] line_level, [7:2] zero
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [owt_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// master side: [0] drive_low, [1] busy_res, [2] done_res,
	// [18:3] temperature, [23:19] zero
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [owt_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [owt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [owt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import owt_pkg::*;

	cfg_t  cfg;
	tick_t tick_s1;
	logic  vld_s1;
	res_t  res;
	res_t  res_s2;
	logic  vld_s2;
	logic  advance;

	owt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// tick moves on when the response register is empty or being drained
	assign advance       = vld_s1 && (!vld_s2 || m_axis_tready);
	assign s_axis_tready = !vld_s1 || advance;

	// input register (payload needs no reset)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			tick_s1.start_req  <= s_axis_tdata[0];
			tick_s1.line_level <= s_axis_tdata[1];
		end
	end

	// sequencer state steps exactly once per tick that moves on
	owt_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.tick   (tick_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (!vld_s2 || m_axis_tready) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = {5'b0, res_s2.temperature, res_s2.done_res,
		res_s2.busy_res, res_s2.drive_low};

endmodule

/* sv/owt_cfg.sv */
// ----------------------------------------------------------------------------
// owt_cfg - timing configuration registers
// Write-only register file holding the bus timing values.
// ----------------------------------------------------------------------------
module owt_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [owt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [owt_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output owt_pkg::cfg_t                  cfg
);
	import owt_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_RESET_PULSE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_DELAY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_HOLD  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_PULSE      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT           = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE         = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_READ_TAIL      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CONVERSION     = 3'd7;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_pulse_ticks    <= 10'd480;
			cfg_q.presence_delay_ticks <= 8'd60;
			cfg_q.presence_hold_ticks  <= 10'd480;
			cfg_q.low_pulse_ticks      <= 4'd1;
			cfg_q.slot_ticks           <= 8'd60;
			cfg_q.sample_ticks         <= 6'd14;
			cfg_q.read_tail_ticks      <= 8'd45;
			cfg_q.conversion_ticks     <= 20'd750000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RESET_PULSE:    cfg_q.reset_pulse_ticks    <= cfg_wdata[9:0];
				REG_PRESENCE_DELAY: cfg_q.presence_delay_ticks <= cfg_wdata[7:0];
				REG_PRESENCE_HOLD:  cfg_q.presence_hold_ticks  <= cfg_wdata[9:0];
				REG_LOW_PULSE:      cfg_q.low_pulse_ticks      <= cfg_wdata[3:0];
				REG_SLOT:           cfg_q.slot_ticks           <= cfg_wdata[7:0];
				REG_SAMPLE:         cfg_q.sample_ticks         <= cfg_wdata[5:0];
				REG_READ_TAIL:      cfg_q.read_tail_ticks      <= cfg_wdata[7:0];
				REG_CONVERSION:     cfg_q.conversion_ticks     <= cfg_wdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* sv/owt_fsm.sv */
// ----------------------------------------------------------------------------
// owt_fsm - one-wire measurement sequencer
// Sequence state and one-pass next-state logic, advanced once per tick.
// ----------------------------------------------------------------------------
module owt_fsm (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  owt_pkg::tick_t tick,
	input  owt_pkg::cfg_t  cfg,
	output owt_pkg::res_t  res
);
	import owt_pkg::*;

	localparam logic [3:0] PH_IDLE     = 4'd0;
	localparam logic [3:0] PH_RST_LOW  = 4'd1;
	localparam logic [3:0] PH_RST_WAIT = 4'd2;
	localparam logic [3:0] PH_PRESENCE = 4'd3;
	localparam logic [3:0] PH_HOLD     = 4'd4;
	localparam logic [3:0] PH_WLOW     = 4'd5;
	localparam logic [3:0] PH_WBIT     = 4'd6;
	localparam logic [3:0] PH_RECOV    = 4'd7;
	localparam logic [3:0] PH_RLOW     = 4'd8;
	localparam logic [3:0] PH_RSAMPLE  = 4'd9;
	localparam logic [3:0] PH_RTAIL    = 4'd10;
	localparam logic [3:0] PH_CONV     = 4'd11;

	localparam logic [2:0] STEP_CONV_SKIP = 3'd0;
	localparam logic [2:0] STEP_CONVERT   = 3'd1;
	localparam logic [2:0] STEP_READ_SKIP = 3'd2;
	localparam logic [2:0] STEP_READ_CMD  = 3'd3;
	localparam logic [2:0] STEP_READ_LO   = 3'd4;
	localparam logic [2:0] STEP_READ_HI   = 3'd5;

	localparam logic [7:0] ROM_SKIP    = 8'hCC;
	localparam logic [7:0] CMD_CONVERT = 8'h44;
	localparam logic [7:0] CMD_READ_SP = 8'hBE;
	localparam logic [2:0] LAST_BIT    = 3'd7;

	function automatic logic [7:0] cmd_byte(input logic [2:0] step);
		logic [7:0] b;
		case (step)
			STEP_CONV_SKIP: b = ROM_SKIP;
			STEP_CONVERT:   b = CMD_CONVERT;
			STEP_READ_SKIP: b = ROM_SKIP;
			STEP_READ_CMD:  b = CMD_READ_SP;
			default:        b = 8'h00;
		endcase
		return b;
	endfunction

	// read bytes come after the four command bytes
	function automatic logic [3:0] slot_phase(input logic [2:0] step);
		return (step >= STEP_READ_LO) ? PH_RLOW : PH_WLOW;
	endfunction

	logic [3:0]         phase_q, phase_d, ph_e;
	logic [COUNT_W-1:0] tick_count_q, tc_d, tc_e, tc_inc, tc_el, limit;
	logic [2:0]         bit_index_q, bit_d, bit_e;
	logic [2:0]         step_q, step_d, step_e;
	logic [7:0]         shift_q, shift_d, shift_r;
	logic [7:0]         low_byte_q, low_d;
	logic [TEMP_W-1:0]  temp_q, temp_d;
	logic               begin_run, hit;
	logic               drive, busy, done;

	always_comb begin
		begin_run = (phase_q == PH_IDLE) && tick.start_req;
		ph_e      = begin_run ? PH_RST_LOW : phase_q;
		tc_e      = begin_run ? '0 : tick_count_q;
		bit_e     = begin_run ? '0 : bit_index_q;
		step_e    = begin_run ? STEP_CONV_SKIP : step_q;

		case (ph_e)
			PH_RST_LOW:  limit = COUNT_W'(cfg.reset_pulse_ticks);
			PH_RST_WAIT: limit = COUNT_W'(cfg.presence_delay_ticks);
			PH_HOLD:     limit = COUNT_W'(cfg.presence_hold_ticks);
			PH_WLOW,
			PH_RLOW:     limit = COUNT_W'(cfg.low_pulse_ticks);
			PH_WBIT:     limit = COUNT_W'(cfg.slot_ticks);
			PH_RSAMPLE:  limit = COUNT_W'(cfg.sample_ticks);
			PH_RTAIL:    limit = COUNT_W'(cfg.read_tail_ticks);
			PH_CONV:     limit = cfg.conversion_ticks;
			default:     limit = '0;
		endcase

		// a limit of zero ends the phase after one tick, same as one
		tc_inc  = tc_e + 1'b1;
		hit     = (tc_inc >= limit);
		tc_el   = hit ? '0 : tc_inc;
		shift_r = (step_e < STEP_READ_LO) ? {1'b0, shift_q[7:1]} : shift_q;

		phase_d = ph_e;
		tc_d    = tc_e;
		bit_d   = bit_e;
		step_d  = step_e;
		shift_d = shift_q;
		low_d   = low_byte_q;
		temp_d  = temp_q;
		drive   = 1'b0;
		busy    = 1'b1;
		done    = 1'b0;

		case (ph_e)
			PH_IDLE: begin
				busy = 1'b0;
			end
			PH_RST_LOW: begin
				drive = 1'b1;
				tc_d  = tc_el;
				if (hit) phase_d = PH_RST_WAIT;
			end
			PH_RST_WAIT: begin
				tc_d = tc_el;
				if (hit) phase_d = PH_PRESENCE;
			end
			PH_PRESENCE: begin
				if (!tick.line_level) begin
					phase_d = PH_HOLD;
					tc_d    = '0;
				end
			end
			PH_HOLD: begin
				tc_d = tc_el;
				if (hit) begin
					bit_d   = '0;
					shift_d = cmd_byte(step_e);
					phase_d = slot_phase(step_e);
				end
			end
			PH_WLOW: begin
				drive = 1'b1;
				tc_d  = tc_el;
				if (hit) phase_d = PH_WBIT;
			end
			PH_WBIT: begin
				drive = ~shift_q[0];
				tc_d  = tc_el;
				if (hit) phase_d = PH_RECOV;
			end
			PH_RLOW: begin
				drive = 1'b1;
				tc_d  = tc_el;
				if (hit) phase_d = PH_RSAMPLE;
			end
			PH_RSAMPLE: begin
				tc_d = tc_el;
				if (hit) begin
					shift_d = {tick.line_level, shift_q[7:1]};
					phase_d = PH_RTAIL;
				end
			end
			PH_RTAIL: begin
				tc_d = tc_el;
				if (hit) phase_d = PH_RECOV;
			end
			PH_CONV: begin
				tc_d = tc_el;
				if (hit) begin
					step_d  = STEP_READ_SKIP;
					phase_d = PH_RST_LOW;
				end
			end
			PH_RECOV: begin
				tc_d    = '0;
				shift_d = shift_r;
				if (bit_e < LAST_BIT) begin
					bit_d   = bit_e + 1'b1;
					phase_d = slot_phase(step_e);
				end else begin
					bit_d = '0;
					case (step_e)
						STEP_CONV_SKIP: begin
							step_d  = STEP_CONVERT;
							shift_d = cmd_byte(STEP_CONVERT);
							phase_d = slot_phase(STEP_CONVERT);
						end
						STEP_CONVERT: begin
							phase_d = PH_CONV;
						end
						STEP_READ_SKIP: begin
							step_d  = STEP_READ_CMD;
							shift_d = cmd_byte(STEP_READ_CMD);
							phase_d = slot_phase(STEP_READ_CMD);
						end
						STEP_READ_CMD: begin
							step_d  = STEP_READ_LO;
							shift_d = cmd_byte(STEP_READ_LO);
							phase_d = slot_phase(STEP_READ_LO);
						end
						STEP_READ_LO: begin
							low_d   = shift_r;
							step_d  = STEP_READ_HI;
							shift_d = cmd_byte(STEP_READ_HI);
							phase_d = slot_phase(STEP_READ_HI);
						end
						STEP_READ_HI: begin
							temp_d  = {shift_r, low_byte_q};
							done    = 1'b1;
							step_d  = STEP_CONV_SKIP;
							phase_d = PH_IDLE;
						end
						default: begin
							step_d  = STEP_CONV_SKIP;
							phase_d = PH_IDLE;
						end
					endcase
				end
			end
			default: begin
				phase_d = PH_IDLE;
				tc_d    = '0;
				busy    = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			tick_count_q <= '0;
			bit_index_q  <= '0;
			step_q       <= STEP_CONV_SKIP;
			shift_q      <= '0;
			low_byte_q   <= '0;
			temp_q       <= '0;
		end else if (en) begin
			phase_q      <= phase_d;
			tick_count_q <= tc_d;
			bit_index_q  <= bit_d;
			step_q       <= step_d;
			shift_q      <= shift_d;
			low_byte_q   <= low_d;
			temp_q       <= temp_d;
		end
	end

	assign res.drive_low   = drive;
	assign res.busy_res    = busy;
	assign res.done_res    = done;
	assign res.temperature = temp_d;

endmodule

/* sv/owt_checker.sv */
// ----------------------------------------------------------------------------
// owt_checker - port-level checks for the one-wire temperature reader
// Watches the stream ports and checks response consistency over time.
// ----------------------------------------------------------------------------
module owt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_axis_tvalid,
	input logic                          s_axis_tready,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [owt_pkg::M_TDATA_W-1:0] m_axis_tdata
);
	import owt_pkg::*;

	// stalled response holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("response changed while stalled");

	// the line is only pulled low during a measurement
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
		else $error("line driven while not busy");

	// done is reported inside the sequence with the line released, never from idle
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1] && !m_axis_tdata[0])
		else $error("done without busy or with line driven");

	// temperature only changes on a done response
	a_temp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$past(m_axis_tvalid && m_axis_tready) && m_axis_tvalid && !m_axis_tdata[2]
		|-> m_axis_tdata[18:3] == $past(m_axis_tdata[18:3]))
		else $error("temperature changed without done");

	// input side is ready for a newly raised request whenever the response register is empty
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready || !s_axis_tvalid || $past(s_axis_tvalid))
		else $error("input stalled with empty response register");

endmodule

bind onewire_temperature_reader owt_checker u_owt_checker (.*);

/* sim/onewire_temperature_reader_test.sv */
// ----------------------------------------------------------------------------
// onewire_temperature_reader_test - testbench for the one-wire temperature reader
// Streams microsecond ticks into the reader and checks every response, tick
// by tick, against a cycle-exact software copy of the measurement sequencer.
// A small bus-side sensor model answers presence and read slots with a chosen
// temperature. Runs cover zero, shortest and top timing registers under
// several valid/ready stall mixes.
// ----------------------------------------------------------------------------
module onewire_temperature_reader_test;
	import owt_pkg::*;

	// sequencer phases, same encoding as the block's state machine
	typedef enum logic [3:0] {
		S_IDLE, S_RESET_LOW, S_RESET_RELEASE, S_PRESENCE, S_HOLD, S_WRITE_LOW,
		S_WRITE_BIT, S_RECOVERY, S_READ_LOW, S_READ_SAMPLE, S_READ_TAIL, S_CONVERT
	} seq_phase_e;

	// which byte of the sequence is on the wire
	typedef enum logic [2:0] {
		STEP_SKIP1, STEP_CONVERT, STEP_SKIP2, STEP_READ_CMD, STEP_READ_LO, STEP_READ_HI
	} byte_step_e;

	// timing register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RESET_PULSE, REG_PRESENCE_DELAY, REG_PRESENCE_HOLD, REG_LOW_PULSE,
		REG_SLOT, REG_SAMPLE, REG_READ_TAIL, REG_CONVERSION
	} reg_idx_e;

	localparam logic [7:0] CMD_SKIP_ROM     = 8'hCC;
	localparam logic [7:0] CMD_CONVERT      = 8'h44;
	localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [S_TDATA_W-1:0]  s_axis_tdata;	// [0] start_req, [1] line_level, [7:2] zero
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_axis_tdata;	// [0] drive_low, [1] busy_res, [2] done_res,
						// [18:3] temperature, [23:19] zero
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// stall mix, percent of cycles
	int unsigned send_gap_pct = 0;
	int unsigned stall_pct    = 0;

	// scoreboard
	res_t        tick_response_q[$];
	int unsigned error_count  = 0;
	int unsigned ticks_sent   = 0;
	int unsigned done_seen    = 0;
	int unsigned measurements = 0;

	// predicted sequencer state and its timing copy
	cfg_t        timing;
	seq_phase_e  seq_phase;
	logic [19:0] tick_cnt;
	logic [2:0]  bit_idx;
	byte_step_e  byte_step;
	logic [7:0]  shreg;
	logic [7:0]  lo_byte;
	logic [15:0] temp_word;

	onewire_temperature_reader u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// sequencer prediction
	// ------------------------------------------------------------------

	// one tick of the current phase; true once it has run lim ticks
	// (a zero limit behaves like one)
	function automatic bit tick_elapsed(logic [19:0] lim);
		tick_cnt = tick_cnt + 20'd1;
		if (tick_cnt >= lim) begin
			tick_cnt = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic [7:0] command_for(byte_step_e s);
		case (s)
			STEP_SKIP1, STEP_SKIP2: return CMD_SKIP_ROM;
			STEP_CONVERT:           return CMD_CONVERT;
			STEP_READ_CMD:          return CMD_READ_SCRATCH;
			default:                return 8'h00;
		endcase
	endfunction

	function automatic void begin_slot();
		tick_cnt = '0;
		if (byte_step >= STEP_READ_LO)
			seq_phase = S_READ_LOW;
		else
			seq_phase = S_WRITE_LOW;
	endfunction

	function automatic void begin_byte();
		bit_idx = '0;
		shreg   = command_for(byte_step);
		begin_slot();
	endfunction

	// advance the sequencer by one tick and return that tick's response
	function automatic res_t predict_tick(tick_t t);
		res_t r;
		r          = '0;
		r.busy_res = 1'b1;
		// the start tick is already the first reset-low tick
		if (seq_phase == S_IDLE && t.start_req) begin
			seq_phase = S_RESET_LOW;
			tick_cnt  = '0;
			byte_step = STEP_SKIP1;
			bit_idx   = '0;
		end
		case (seq_phase)
			S_IDLE: r.busy_res = 1'b0;
			S_RESET_LOW: begin
				r.drive_low = 1'b1;
				if (tick_elapsed(20'(timing.reset_pulse_ticks)))
					seq_phase = S_RESET_RELEASE;
			end
			S_RESET_RELEASE: begin
				if (tick_elapsed(20'(timing.presence_delay_ticks)))
					seq_phase = S_PRESENCE;
			end
			// no timeout: a low line ends the wait on that same tick
			S_PRESENCE: begin
				if (!t.line_level) begin
					seq_phase = S_HOLD;
					tick_cnt  = '0;
				end
			end
			S_HOLD: begin
				if (tick_elapsed(20'(timing.presence_hold_ticks)))
					begin_byte();
			end
			S_WRITE_LOW: begin
				r.drive_low = 1'b1;
				if (tick_elapsed(20'(timing.low_pulse_ticks)))
					seq_phase = S_WRITE_BIT;
			end
			// a one only releases the line, a zero keeps it low
			S_WRITE_BIT: begin
				r.drive_low = !shreg[0];
				if (tick_elapsed(20'(timing.slot_ticks)))
					seq_phase = S_RECOVERY;
			end
			S_READ_LOW: begin
				r.drive_low = 1'b1;
				if (tick_elapsed(20'(timing.low_pulse_ticks)))
					seq_phase = S_READ_SAMPLE;
			end
			// sample on the last release tick, bits arrive LSB first
			S_READ_SAMPLE: begin
				if (tick_elapsed(20'(timing.sample_ticks))) begin
					shreg     = {t.line_level, shreg[7:1]};
					seq_phase = S_READ_TAIL;
				end
			end
			S_READ_TAIL: begin
				if (tick_elapsed(20'(timing.read_tail_ticks)))
					seq_phase = S_RECOVERY;
			end
			S_CONVERT: begin
				if (tick_elapsed(timing.conversion_ticks)) begin
					byte_step = STEP_SKIP2;
					seq_phase = S_RESET_LOW;
				end
			end
			// recovery tick between slots, line released
			S_RECOVERY: begin
				tick_cnt = '0;
				if (byte_step < STEP_READ_LO)
					shreg = shreg >> 1;
				if (bit_idx < 3'd7) begin
					bit_idx = bit_idx + 3'd1;
					begin_slot();
				end else begin
					bit_idx = '0;
					case (byte_step)
						STEP_SKIP1: begin
							byte_step = STEP_CONVERT;
							begin_byte();
						end
						STEP_CONVERT: seq_phase = S_CONVERT;
						STEP_SKIP2: begin
							byte_step = STEP_READ_CMD;
							begin_byte();
						end
						STEP_READ_CMD: begin
							byte_step = STEP_READ_LO;
							begin_byte();
						end
						STEP_READ_LO: begin
							lo_byte   = shreg;
							byte_step = STEP_READ_HI;
							begin_byte();
						end
						// done tick: the new temperature shows on this response
						STEP_READ_HI: begin
							temp_word   = {shreg, lo_byte};
							r.done_res  = 1'b1;
							byte_step   = STEP_SKIP1;
							seq_phase   = S_IDLE;
						end
						default: begin
							byte_step = STEP_SKIP1;
							seq_phase = S_IDLE;
						end
					endcase
				end
			end
			default: begin
				seq_phase  = S_IDLE;
				tick_cnt   = '0;
				r.busy_res = 1'b0;
			end
		endcase
		r.temperature = temp_word;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// response side: random backpressure and in-order checking
	// ------------------------------------------------------------------

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);

	function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin : check_response
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (tick_response_q.size() == 0) begin
				$error("response with no tick outstanding: %h", m_axis_tdata);
				error_count++;
			end else begin
				want = tick_response_q.pop_front();
				if (want.done_res)
					done_seen++;
				compare_field("drive_low", 16'(want.drive_low), 16'(m_axis_tdata[0]));
				compare_field("busy_res", 16'(want.busy_res), 16'(m_axis_tdata[1]));
				compare_field("done_res", 16'(want.done_res), 16'(m_axis_tdata[2]));
				compare_field("temperature", want.temperature, m_axis_tdata[18:3]);
			end
		end
	end

	// ------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------

	task automatic set_mix(int unsigned gap, int unsigned stall);
		send_gap_pct = gap;
		stall_pct    = stall;
	endtask

	// send one tick request, with random gaps ahead of it; the prediction
	// is made once the request is taken
	task automatic send_tick(input logic start, input logic line);
		tick_t t;
		t.start_req  = start;
		t.line_level = line;
		while ($urandom_range(0, 99) < send_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'd0, t.line_level, t.start_req};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		tick_response_q.push_back(predict_tick(t));
		ticks_sent++;
	endtask

	// stop sending and let every outstanding response drain
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (tick_response_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write all eight timing registers; junk sets bits above each
	// register's width, which the block must drop
	task automatic load_timing(cfg_t c, bit junk);
		logic [19:0] val [8];
		int unsigned wid [8];
		logic [31:0] noise;
		val = '{20'(c.reset_pulse_ticks), 20'(c.presence_delay_ticks),
			20'(c.presence_hold_ticks), 20'(c.low_pulse_ticks), 20'(c.slot_ticks),
			20'(c.sample_ticks), 20'(c.read_tail_ticks), c.conversion_ticks};
		wid = '{10, 8, 10, 4, 8, 6, 8, 20};
		settle();
		for (int i = 0; i < 8; i++) begin
			noise = junk ? ($urandom << wid[i]) : 32'd0;
			cfg_we    <= 1'b1;
			cfg_index <= reg_idx_e'(i);
			cfg_wdata <= val[i] | noise[19:0];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		timing = c;
	endtask

	// one measurement with a simple sensor on the bus: presence comes after
	// a random wait, read slots return word LSB first. Noisy runs answer
	// read slots with random levels and hold off presence longer. Stray
	// starts while busy are mixed in. pause_at holds the sender until the
	// responses drain; stop_after abandons the run after that many ticks;
	// mix_every hands the run to the sender, receiver and combined stall
	// mixes in turn, that many ticks each.
	task automatic run_measurement(logic [15:0] word, bit noisy, int unsigned pause_at,
			int unsigned stop_after, int unsigned mix_every);
		int unsigned gap_mix [4];
		int unsigned stall_mix [4];
		int unsigned mix_sel;
		int unsigned n;
		logic        line;
		gap_mix   = '{0, 47, 0, 38};
		stall_mix = '{0, 0, 47, 38};
		mix_sel   = 1;
		n         = 0;
		measurements++;
		if (mix_every != 0)
			set_mix(gap_mix[mix_sel], stall_mix[mix_sel]);
		send_tick(1'b1, 1'($urandom_range(0, 1)));
		while (seq_phase != S_IDLE && !(stop_after != 0 && n >= stop_after)) begin
			case (seq_phase)
				S_PRESENCE: line = ($urandom_range(0, noisy ? 15 : 3) != 0);
				S_READ_SAMPLE, S_READ_TAIL:
					line = noisy ? 1'($urandom_range(0, 1))
						: word[{byte_step == STEP_READ_HI, bit_idx}];
				default: line = 1'($urandom_range(0, 1));
			endcase
			n++;
			if (n == pause_at)
				settle();
			if (mix_every != 0 && n % mix_every == 0 && mix_sel < 3) begin
				mix_sel++;
				set_mix(gap_mix[mix_sel], stall_mix[mix_sel]);
			end
			send_tick($urandom_range(0, 3) == 0, line);
		end
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// reset timings untouched: idle ticks must show busy low and a zero temperature
	task automatic test_idle_after_reset();
		for (int i = 0; i < 6; i++)
			send_tick(1'b0, i[0]);
	endtask

	// every register zero acts as one tick, junk above the fields is dropped;
	// also the drain pause mid-run and the largest temperature word
	task automatic test_zero_registers();
		load_timing('0, 1'b1);
		run_measurement(16'h7FFF, 1'b0, 40, 0, 0);
	endtask

	// shortest timings, each register randomly zero or one, and the most
	// negative temperature word; the stall mixes take turns over the run
	task automatic test_temperature_extremes();
		cfg_t c;
		c.reset_pulse_ticks    = 10'($urandom_range(0, 1));
		c.presence_delay_ticks = 8'($urandom_range(0, 1));
		c.presence_hold_ticks  = 10'($urandom_range(0, 1));
		c.low_pulse_ticks      = 4'($urandom_range(0, 1));
		c.slot_ticks           = 8'($urandom_range(0, 1));
		c.sample_ticks         = 6'($urandom_range(0, 1));
		c.read_tail_ticks      = 8'($urandom_range(0, 1));
		c.conversion_ticks     = 20'($urandom_range(0, 1));
		load_timing(c, 1'b1);
		run_measurement(16'h8000, 1'b0, 0, 0, 58);
		set_mix(0, 0);
	endtask

	// every register at its top value; only the start of the long reset
	// pulse fits, so the run is left unfinished and this goes last
	task automatic test_max_conversion();
		cfg_t c;
		c = '{reset_pulse_ticks: 10'd1023, presence_delay_ticks: 8'd255,
			presence_hold_ticks: 10'd1023, low_pulse_ticks: 4'd15, slot_ticks: 8'd255,
			sample_ticks: 6'd63, read_tail_ticks: 8'd255, conversion_ticks: 20'hFFFFF};
		set_mix(38, 38);
		load_timing(c, 1'b0);
		run_measurement(16'h0550, 1'b1, 0, 40, 0);
		set_mix(0, 0);
	endtask

	initial begin
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_we        = 1'b0;
		cfg_index     = REG_RESET_PULSE;
		cfg_wdata     = '0;
		arst_n        = 1'b0;

		// power-on timing and sequencer state
		timing = '{reset_pulse_ticks: 10'd480, presence_delay_ticks: 8'd60,
			presence_hold_ticks: 10'd480, low_pulse_ticks: 4'd1, slot_ticks: 8'd60,
			sample_ticks: 6'd14, read_tail_ticks: 8'd45, conversion_ticks: 20'd750000};
		seq_phase = S_IDLE;
		tick_cnt  = '0;
		bit_idx   = '0;
		byte_step = STEP_SKIP1;
		shreg     = '0;
		lo_byte   = '0;
		temp_word = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_after_reset();
		test_zero_registers();
		test_temperature_extremes();
		test_max_conversion();

		settle();
		repeat (8) @(posedge clk);
		$display("Ran %0d measurements over %0d ticks with zero, shortest and top timings",
			measurements, ticks_sent);
		$display("across all four stall mixes; %0d done pulses, %0d mismatches.",
			done_seen, error_count);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// watchdog, several times the slowest expected run
	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule
